// ----- rtl/speed_gain_schedule_interp_unit_assert.svh -----
// Assertion macros for the gain schedule unit; clk and rst are taken from the enclosing module.
`ifndef SPEED_GAIN_SCHEDULE_INTERP_UNIT_ASSERT_SVH
`define SPEED_GAIN_SCHEDULE_INTERP_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SGSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgsi: implication check failed");

`define SGSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgsi: next-cycle check failed");

`else

`define SGSI_ASSERT_IMP(lbl, ante, cons)
`define SGSI_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/sgsi_pkg.sv -----
`timescale 1ns / 1ps
package sgsi_pkg;

  localparam int ROM_ROWS      = 16;
  localparam int TABLE_ENTRIES = 16;
  localparam int USED_ROWS     = (TABLE_ENTRIES > ROM_ROWS) ? ROM_ROWS :
                                 ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int SEGS          = ROM_ROWS - 1;
  localparam int SEG_W         = $clog2(ROM_ROWS);

  localparam int SPD_W  = 16;
  localparam int KP_W   = 14;
  localparam int KI_W   = 13;
  localparam int GAIN_W = (KP_W > KI_W) ? KP_W : KI_W;
  // widest segment is 2000 rpm
  localparam int OFF_W  = 11;
  localparam int PROD_W = OFF_W + GAIN_W;

  // quotient = (prod * rcp) >> RCP_SHIFT, short by at most one
  localparam int          RCP_SHIFT = PROD_W;
  localparam int          RCP_W     = 20;
  localparam int unsigned RCP_ONE   = 32'd1 << RCP_SHIFT;

  localparam logic [SPD_W-1:0] SPD_TAB [ROM_ROWS] = '{
    16'd0,    16'd100,  16'd250,  16'd500,  16'd750,  16'd1000, 16'd1500, 16'd2000,
    16'd2500, 16'd3000, 16'd3500, 16'd4000, 16'd5000, 16'd6000, 16'd8000, 16'd10000
  };

  localparam logic [KP_W-1:0] KP_TAB [ROM_ROWS] = '{
    14'd14336, 14'd14336, 14'd13107, 14'd11469, 14'd10240, 14'd9011, 14'd7373, 14'd6144,
    14'd4915,  14'd4096,  14'd3277,  14'd2662,  14'd2048,  14'd1638, 14'd1229, 14'd1024
  };

  localparam logic [KI_W-1:0] KI_TAB [ROM_ROWS] = '{
    13'd7864, 13'd7864, 13'd7209, 13'd6554, 13'd5898, 13'd5243, 13'd4260, 13'd3604,
    13'd2949, 13'd2294, 13'd1966, 13'd1638, 13'd1311, 13'd983,  13'd655,  13'd524
  };

  localparam logic [OFF_W-1:0] DX_TAB [SEGS] = '{
    11'd100, 11'd150, 11'd250, 11'd250, 11'd250, 11'd500,  11'd500, 11'd500,
    11'd500, 11'd500, 11'd500, 11'd1000, 11'd1000, 11'd2000, 11'd2000
  };

  localparam logic [RCP_W-1:0] RCP_TAB [SEGS] = '{
    RCP_W'(RCP_ONE / 100),  RCP_W'(RCP_ONE / 150),  RCP_W'(RCP_ONE / 250),
    RCP_W'(RCP_ONE / 250),  RCP_W'(RCP_ONE / 250),  RCP_W'(RCP_ONE / 500),
    RCP_W'(RCP_ONE / 500),  RCP_W'(RCP_ONE / 500),  RCP_W'(RCP_ONE / 500),
    RCP_W'(RCP_ONE / 500),  RCP_W'(RCP_ONE / 500),  RCP_W'(RCP_ONE / 1000),
    RCP_W'(RCP_ONE / 1000), RCP_W'(RCP_ONE / 2000), RCP_W'(RCP_ONE / 2000)
  };

  typedef struct packed {
    logic s3;
    logic s4;
  } sgsi_load_t;

endpackage

// ----- rtl/sgsi_quot.sv -----
`timescale 1ns / 1ps
module sgsi_quot import sgsi_pkg::*; (
  input  logic              clk,
  input  sgsi_load_t        load,
  input  logic [PROD_W-1:0] prod,
  input  logic [SEG_W-1:0]  seg,
  output logic [GAIN_W-1:0] quot
);

  logic [PROD_W+RCP_W-1:0]  full;
  logic [GAIN_W-1:0]        est_next;
  logic [PROD_W-1:0]        prod3;
  logic [GAIN_W-1:0]        est;
  logic [SEG_W-1:0]         seg3;
  logic [GAIN_W+OFF_W-1:0]  back;
  logic [PROD_W-1:0]        rem;
  logic [GAIN_W-1:0]        quot_next;

  assign full     = (PROD_W+RCP_W)'(prod) * (PROD_W+RCP_W)'(RCP_TAB[seg]);
  assign est_next = full[RCP_SHIFT +: GAIN_W];

  always_ff @(posedge clk) begin
    if (load.s3) begin
      prod3 <= prod;
      est   <= est_next;
      seg3  <= seg;
    end
  end

  assign back      = (GAIN_W+OFF_W)'(est) * (GAIN_W+OFF_W)'(DX_TAB[seg3]);
  assign rem       = prod3 - PROD_W'(back);
  assign quot_next = (rem >= PROD_W'(DX_TAB[seg3])) ? GAIN_W'(est + 1'b1) : est;

  always_ff @(posedge clk) begin
    if (load.s4) begin
      quot <= quot_next;
    end
  end

endmodule

// ----- rtl/speed_gain_schedule_interp_unit.sv -----
`timescale 1ns / 1ps
// channel  valid      ready      payload
// in       in_valid   in_ready   speed (s16)
// out      out_valid  out_ready  kp_q12 (u14), ki_q16 (u13)
//
// Five register stages: segment search, offset x slope, reciprocal multiply,
// remainder correction, gain sum. One request per cycle while the output is not stalled.
// rst clears the stage valid bits only.
// A stall holds each occupied stage; empty stages still fill behind it.
`include "speed_gain_schedule_interp_unit_assert.svh"
module speed_gain_schedule_interp_unit import sgsi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SPD_W-1:0] speed,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KP_W-1:0]         kp_q12,
  output logic [KI_W-1:0]         ki_q16
);

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: magnitude and segment search
  logic [SPD_W-1:0] neg_spd;
  logic [SPD_W-1:0] mag_next;
  logic [SEG_W-1:0] seg_next;
  logic             hi_next;
  logic [SPD_W-1:0] mag1;
  logic [SEG_W-1:0] seg1;
  logic             hi1;

  assign neg_spd  = SPD_W'(-speed);
  assign mag_next = speed[SPD_W-1] ? neg_spd : SPD_W'(speed);
  assign hi_next  = mag_next >= SPD_TAB[USED_ROWS-1];

  always_comb begin
    seg_next = '0;
    for (int i = 1; i < USED_ROWS - 1; i++) begin
      if (mag_next >= SPD_TAB[i]) seg_next = SEG_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mag1 <= mag_next;
      seg1 <= seg_next;
      hi1  <= hi_next;
    end
  end

  // stage 2: offset into segment times |dy|; above range the offset is the full width
  logic [SEG_W-1:0]  seg1_up;
  logic [OFF_W-1:0]  off;
  logic [KP_W-1:0]   dkp;
  logic [KI_W-1:0]   dki;
  logic [PROD_W-1:0] pkp_next;
  logic [PROD_W-1:0] pki_next;
  logic [PROD_W-1:0] pkp2;
  logic [PROD_W-1:0] pki2;
  logic [SEG_W-1:0]  seg2;

  assign seg1_up = seg1 + SEG_W'(1);
  assign off = hi1 ? DX_TAB[seg1] : OFF_W'(mag1 - SPD_TAB[seg1]);
  assign dkp = (KP_TAB[seg1_up] < KP_TAB[seg1]) ? KP_TAB[seg1] - KP_TAB[seg1_up]
                                                : KP_TAB[seg1_up] - KP_TAB[seg1];
  assign dki = (KI_TAB[seg1_up] < KI_TAB[seg1]) ? KI_TAB[seg1] - KI_TAB[seg1_up]
                                                : KI_TAB[seg1_up] - KI_TAB[seg1];
  assign pkp_next = PROD_W'(off) * PROD_W'(dkp);
  assign pki_next = PROD_W'(off) * PROD_W'(dki);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      pkp2 <= pkp_next;
      pki2 <= pki_next;
      seg2 <= seg1;
    end
  end

  // stages 3 and 4: exact floor division by the segment width
  sgsi_load_t       load;
  logic [GAIN_W-1:0] qkp;
  logic [GAIN_W-1:0] qki;
  logic [SEG_W-1:0]  seg3;
  logic [SEG_W-1:0]  seg4;

  assign load.s3 = rdy3;
  assign load.s4 = rdy4;

  sgsi_quot u_quot_kp (
    .clk  (clk),
    .load (load),
    .prod (pkp2),
    .seg  (seg2),
    .quot (qkp)
  );

  sgsi_quot u_quot_ki (
    .clk  (clk),
    .load (load),
    .prod (pki2),
    .seg  (seg2),
    .quot (qki)
  );

  always_ff @(posedge clk) begin
    if (rdy3) seg3 <= seg2;
    if (rdy4) seg4 <= seg3;
  end

  // stage 5: y0 +/- quotient
  logic [SEG_W-1:0] seg4_up;
  logic [KP_W-1:0]  kp_next;
  logic [KI_W-1:0]  ki_next;

  assign seg4_up = seg4 + SEG_W'(1);
  assign kp_next = (KP_TAB[seg4_up] < KP_TAB[seg4]) ? KP_TAB[seg4] - KP_W'(qkp)
                                                    : KP_TAB[seg4] + KP_W'(qkp);
  assign ki_next = (KI_TAB[seg4_up] < KI_TAB[seg4]) ? KI_TAB[seg4] - KI_W'(qki)
                                                    : KI_TAB[seg4] + KI_W'(qki);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      kp_q12 <= kp_next;
      ki_q16 <= ki_next;
    end
  end

  `SGSI_ASSERT_IMP(a_seg_range, v1, seg1 <= SEG_W'(USED_ROWS - 2))
  `SGSI_ASSERT_NXT(a_stage_hold, v3 && !rdy4, v3)
  `SGSI_ASSERT_IMP(a_kp_bounds, v5, kp_q12 <= KP_TAB[0] && kp_q12 >= KP_TAB[USED_ROWS-1])
  `SGSI_ASSERT_IMP(a_ki_bounds, v5, ki_q16 <= KI_TAB[0] && ki_q16 >= KI_TAB[USED_ROWS-1])

endmodule
